@@ src/ssr_pkg.sv @@
package ssr_pkg;

    // Bank geometry
    localparam int NUM_STACKS  = 8;
    localparam int STACK_DEPTH = 16;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int SEL_W    = 3;
    localparam int WORD_W   = 32;

    // Derived widths
    localparam int IDX_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int FILL_W   = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W   = $clog2(NUM_STACKS * STACK_DEPTH);

    // Answer for a read that finds nothing
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd404;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_TOP   = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

endpackage

@@ src/stack_set_rollover.sv @@
// stack_set_rollover: a bank of NUM_STACKS stacks, STACK_DEPTH words each,
// held in one single-port-write, registered-read word memory, with a fill
// counter per stack and a current-stack pointer. Each input beat is one
// operation (push, pop, top, empty query) and gives exactly one output beat.
// Push writes onto the current stack and rolls over to the next stack when
// the current one is full; if that stack is full too, or there is no next
// stack, the push is refused and full_flag is set. Pop walks down from the
// selected stack to the nearest non-empty one and removes its top word; the
// empty query walks down from the current stack; top peeks at the selected
// stack only. A read that finds nothing answers -404 with empty_flag set.
// Timing: the block takes one beat at a time (in_ready is low while an
// operation runs). A small sequencer steps one fill counter per cycle
// through the walk: an operation is accepted in ST_IDLE, checked in
// ST_CHECK, read from memory in ST_READ and ST_CAPTURE on pop and top,
// and loaded into the output register in ST_OUT when it is free. The
// output register decouples the two sides, so a new beat is taken while
// a finished result still waits for out_ready. No clearing pass is
// needed after reset: only words below a stack's fill count are ever read.
module stack_set_rollover
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ssr_pkg::FUNC_W-1:0]           func,
    input  logic signed [ssr_pkg::WORD_W-1:0]    push_value,
    input  logic [ssr_pkg::SEL_W-1:0]            stack_select,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ssr_pkg::WORD_W-1:0]    read_value,
    output logic                                 empty_flag,
    output logic                                 full_flag
);
    import ssr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_CAPTURE,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    func_t                     func_reg;
    logic signed [WORD_W-1:0]  value_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [IDX_W-1:0]          active_reg;
    logic                      rolled_reg;
    logic [FILL_W-1:0]         fill_reg [NUM_STACKS];

    // Result staged before the output register
    logic signed [WORD_W-1:0]  res_value_reg;
    logic                      res_empty_reg;
    logic                      res_full_reg;

    // Output register
    logic                      out_valid_reg;
    logic signed [WORD_W-1:0]  out_value_reg;
    logic                      out_empty_reg;
    logic                      out_full_reg;

    // Word memory
    logic signed [WORD_W-1:0]  mem [NUM_STACKS * STACK_DEPTH];
    logic [ADDR_W-1:0]         rd_addr_reg;
    logic signed [WORD_W-1:0]  rd_data_reg;

    logic [FILL_W-1:0]         fill_cur;
    logic                      cur_full;
    logic                      cur_empty;
    logic                      can_roll;
    logic [ADDR_W-1:0]         base_addr;
    logic [ADDR_W-1:0]         top_addr;
    logic [ADDR_W-1:0]         wr_addr;
    logic                      mem_we;
    logic                      out_free;
    logic [IDX_W-1:0]          sel_clamped;

    // Single read port on the fill counters, addressed by the walk pointer
    assign fill_cur  = fill_reg[idx_reg];
    assign cur_full  = (fill_cur == FILL_W'(STACK_DEPTH));
    assign cur_empty = (fill_cur == '0);
    assign can_roll  = !rolled_reg && ((int'(idx_reg) + 1) < NUM_STACKS);
    assign base_addr = ADDR_W'(idx_reg) * ADDR_W'(STACK_DEPTH);
    assign wr_addr   = base_addr + ADDR_W'(fill_cur);
    assign top_addr  = wr_addr - ADDR_W'(1);
    assign mem_we    = (state_reg == ST_CHECK) && (func_reg == FUNC_PUSH) && !cur_full;
    assign out_free  = !out_valid_reg || out_ready;

    // Clamp a stack index beyond the last stack
    always_comb
    begin
        if (int'(stack_select) >= NUM_STACKS)
        begin
            sel_clamped = IDX_W'(NUM_STACKS - 1);
        end
        else
        begin
            sel_clamped = IDX_W'(stack_select);
        end
    end

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign empty_flag = out_empty_reg;
    assign full_flag  = out_full_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= value_reg;
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FUNC_PUSH;
            value_reg     <= '0;
            idx_reg       <= '0;
            active_reg    <= '0;
            rolled_reg    <= 1'b0;
            res_value_reg <= '0;
            res_empty_reg <= 1'b0;
            res_full_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_empty_reg <= 1'b0;
            out_full_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            // Drop the output beat once taken; in ST_OUT the reload below owns it
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg      <= func_t'(func);
                        value_reg     <= push_value;
                        rolled_reg    <= 1'b0;
                        res_value_reg <= '0;
                        res_empty_reg <= 1'b0;
                        res_full_reg  <= 1'b0;
                        if (func_t'(func) inside {FUNC_PUSH, FUNC_QUERY})
                        begin
                            idx_reg <= active_reg;
                        end
                        else
                        begin
                            idx_reg <= sel_clamped;
                        end
                        state_reg <= ST_CHECK;
                    end
                end

                ST_CHECK:
                begin
                    case (func_reg)
                        FUNC_PUSH:
                        begin
                            if (!cur_full)
                            begin
                                fill_reg[idx_reg] <= fill_cur + FILL_W'(1);
                                state_reg         <= ST_OUT;
                            end
                            else if (can_roll)
                            begin
                                // Advance to the next stack and check again
                                idx_reg    <= idx_reg + IDX_W'(1);
                                active_reg <= idx_reg + IDX_W'(1);
                                rolled_reg <= 1'b1;
                            end
                            else
                            begin
                                res_full_reg <= 1'b1;
                                state_reg    <= ST_OUT;
                            end
                        end
                        FUNC_POP:
                        begin
                            if (!cur_empty)
                            begin
                                fill_reg[idx_reg] <= fill_cur - FILL_W'(1);
                                rd_addr_reg       <= top_addr;
                                state_reg         <= ST_READ;
                            end
                            else if (idx_reg == '0)
                            begin
                                res_value_reg <= EMPTY_WORD;
                                res_empty_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                            else
                            begin
                                idx_reg <= idx_reg - IDX_W'(1);
                            end
                        end
                        FUNC_TOP:
                        begin
                            if (!cur_empty)
                            begin
                                rd_addr_reg <= top_addr;
                                state_reg   <= ST_READ;
                            end
                            else
                            begin
                                res_value_reg <= EMPTY_WORD;
                                res_empty_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (!cur_empty)
                            begin
                                state_reg <= ST_OUT;
                            end
                            else if (idx_reg == '0)
                            begin
                                res_value_reg <= EMPTY_WORD;
                                res_empty_reg <= 1'b1;
                                state_reg     <= ST_OUT;
                            end
                            else
                            begin
                                idx_reg <= idx_reg - IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            state_reg <= ST_OUT;
                        end
                    endcase
                end

                ST_READ:
                begin
                    // Memory read data lands in rd_data_reg at this edge
                    state_reg <= ST_CAPTURE;
                end

                ST_CAPTURE:
                begin
                    res_value_reg <= rd_data_reg;
                    state_reg     <= ST_OUT;
                end

                ST_OUT:
                begin
                    // Hold the result until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= res_value_reg;
                        out_empty_reg <= res_empty_reg;
                        out_full_reg  <= res_full_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/ssr_checker.sv @@
module ssr_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [ssr_pkg::WORD_W-1:0]    read_value,
    input  logic                                 empty_flag,
    input  logic                                 full_flag
);
    import ssr_pkg::*;

    // A refused push and an empty read never share a beat
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(empty_flag && full_flag))
        else $error("empty_flag and full_flag both set");

    // An empty answer always carries the empty word
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && empty_flag) |-> (read_value == EMPTY_WORD))
        else $error("empty beat without -404");

    // A refused push reads back zero
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_flag) |-> (read_value == '0))
        else $error("full beat with nonzero read_value");

    // One operation at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while operation in flight");

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(read_value)
            && $stable(empty_flag) && $stable(full_flag)))
        else $error("output beat changed while stalled");

endmodule

bind stack_set_rollover ssr_checker u_ssr_checker (.*);
